@@ hw/rtl/rmq_pkg.sv @@
// Shared types, widths and branch codes for the rotation matrix to quaternion block.
// No dependencies; every other file refers to this package by scoped names.
package rmq_pkg;

  // Output word width of the quaternion components.
  localparam int DATA_WIDTH = 32;

  localparam int IN_W   = 32;           // matrix element width
  localparam int FRAC   = 30;           // Q2.30 fraction bits
  localparam int EXT_W  = IN_W + 3;     // room for 1 + three elements
  localparam int RAD_W  = 33;           // clamped radicand, always below 2^33
  localparam int ROOT_W = 32;           // floor(sqrt(rad * 2^30))
  localparam int MAG_W  = IN_W + 1;     // magnitude of a sum of two elements
  localparam int DSH    = 29;           // dividend is magnitude * 2^29
  localparam int QUO_W  = MAG_W + DSH;  // full quotient width
  localparam int SAT_W  = 65;           // work width for saturation

  localparam int FRONT_STAGES = 2;
  localparam int BACK_STAGES  = 1;
  localparam int LATENCY = FRONT_STAGES + ROOT_W + QUO_W + BACK_STAGES;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_COL0  = 2'd1,
    BR_COL1  = 2'd2,
    BR_COL2  = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [IN_W-1:0] r00;
    logic signed [IN_W-1:0] r01;
    logic signed [IN_W-1:0] r02;
    logic signed [IN_W-1:0] r10;
    logic signed [IN_W-1:0] r11;
    logic signed [IN_W-1:0] r12;
    logic signed [IN_W-1:0] r20;
    logic signed [IN_W-1:0] r21;
    logic signed [IN_W-1:0] r22;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic [1:0]                   branch_taken;
    logic                         degenerate;
  } out_t;

  // Front end result: radicand plus the three off-diagonal numerators.
  typedef struct packed {
    branch_t               branch;
    logic [RAD_W-1:0]      rad;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } front_t;

  typedef struct packed {
    branch_t               branch;
    logic [ROOT_W-1:0]     root;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } root_t;

  typedef struct packed {
    branch_t               branch;
    logic [ROOT_W-1:0]     root;
    logic [2:0]            neg;
    logic [2:0][QUO_W-1:0] quo;
  } quo_t;

endpackage

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// Top level of the rotation matrix to quaternion converter: threshold register and pipeline.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div and rmq_back.
//
//   port group               dir  handshake            transaction
//   start / busy / rmat      in   start & !busy        nine Q2.30 matrix elements
//   done / result            out  done, one cycle      quaternion, branch, degenerate flag
//   cfg_wr_en / cfg_wr_data  in   cfg_wr_en            trace threshold thr (31 bits)
//
// One transaction may enter every clock cycle; busy is never raised.
// From accept to done a transaction passes two front stages, 32 square root steps
// (one root bit each), 62 divider steps (one quotient bit each, three lanes sharing
// the divisor) and one output register; rmq_pkg::LATENCY is their sum.
// Synchronous reset clears the valid bits of every stage and sets the threshold to 1.
// The receiver cannot stall; each result is shown for exactly one cycle.
module rotation_matrix_to_quaternion (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rmq_pkg::in_t  rmat,
  output logic          done,
  output rmq_pkg::out_t result,
  input  logic          cfg_wr_en,
  input  logic [30:0]   cfg_wr_data
);

  logic            trace_threshold;
  logic [30:0]     thr;
  logic            accept;
  logic            f_vld, s_vld, d_vld;
  rmq_pkg::front_t f_data;
  rmq_pkg::root_t  s_data;
  rmq_pkg::quo_t   d_data;

  // The pipeline never holds off the sender.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Hold the threshold; write it whenever the enable is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr             <= 31'd1;
      trace_threshold <= 1'b0;
    end else if (cfg_wr_en) begin
      thr             <= cfg_wr_data;
      trace_threshold <= 1'b1;
    end
  end

  // Select the branch and form radicand and numerators.
  rmq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .in_data  (rmat),
    .thr      (thr),
    .out_vld  (f_vld),
    .out_data (f_data)
  );

  // Advance through the root pipeline.
  rmq_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (f_vld),
    .in_data  (f_data),
    .out_vld  (s_vld),
    .out_data (s_data)
  );

  // Divide the three numerators by twice the root.
  rmq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s_vld),
    .in_data  (s_data),
    .out_vld  (d_vld),
    .out_data (d_data)
  );

  // Saturate, place components and drive the result strobe.
  rmq_back u_back (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (d_vld),
    .in_data (d_data),
    .done    (done),
    .result  (result)
  );

  // Every accepted transaction comes out after exactly the pipeline latency.
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(rmq_pkg::LATENCY) done)
    else $error("accepted transaction did not complete on time");

  // A degenerate result carries an all-zero quaternion.
  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    (done && result.degenerate) |->
      (result.quat_x == '0 && result.quat_y == '0 &&
       result.quat_z == '0 && result.quat_w == '0))
    else $error("degenerate result with nonzero quaternion");

  // The diagonal component of the trace branch is a half root and never negative.
  a_trace_w_pos : assert property (@(posedge clk) disable iff (rst)
    (done && result.branch_taken == rmq_pkg::BR_TRACE) |->
      !result.quat_w[rmq_pkg::DATA_WIDTH-1])
    else $error("trace branch produced negative w");

  // The threshold only changes through a write.
  a_thr_hold : assert property (@(posedge clk) disable iff (rst)
    (!$past(cfg_wr_en) && trace_threshold) |-> $stable(thr))
    else $error("threshold changed without a write");

endmodule

@@ hw/rtl/rmq_front.sv @@
// Front end: input register, then trace / branch selection, radicand and numerators.
// Depends on rmq_pkg.
module rmq_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  rmq_pkg::in_t              in_data,
  input  logic [30:0]               thr,
  output logic                      out_vld,
  output rmq_pkg::front_t           out_data
);

  localparam int EW = rmq_pkg::EXT_W;
  localparam int MW = rmq_pkg::MAG_W;
  localparam logic signed [EW-1:0] ONE = EW'(64'd1 << rmq_pkg::FRAC);

  logic         vld1;
  rmq_pkg::in_t mat;

  logic signed [EW-1:0] e00, e11, e22, t, rad_s, thr_s;
  logic signed [MW-1:0] n_d21m12, n_d02m20, n_d10m01, n_s10p01, n_s02p20, n_s21p12;
  logic signed [MW-1:0] n0, n1, n2;
  rmq_pkg::branch_t     br;
  rmq_pkg::front_t      fr;

  function automatic logic [MW-1:0] mag_of(input logic signed [MW-1:0] n);
    mag_of = n[MW-1] ? MW'(-n) : n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_vld;
    end
    mat <= in_data;
  end

  always_comb begin
    e00   = EW'(mat.r00);
    e11   = EW'(mat.r11);
    e22   = EW'(mat.r22);
    t     = ONE + e00 + e11 + e22;
    thr_s = $signed({{(EW-31){1'b0}}, thr});

    n_d21m12 = MW'(mat.r21) - MW'(mat.r12);
    n_d02m20 = MW'(mat.r02) - MW'(mat.r20);
    n_d10m01 = MW'(mat.r10) - MW'(mat.r01);
    n_s10p01 = MW'(mat.r10) + MW'(mat.r01);
    n_s02p20 = MW'(mat.r02) + MW'(mat.r20);
    n_s21p12 = MW'(mat.r21) + MW'(mat.r12);

    if (t > thr_s) begin
      br = rmq_pkg::BR_TRACE;
    end else if (mat.r00 > mat.r11 && mat.r00 > mat.r22) begin
      br = rmq_pkg::BR_COL0;
    end else if (mat.r11 > mat.r22) begin
      br = rmq_pkg::BR_COL1;
    end else begin
      br = rmq_pkg::BR_COL2;
    end

    // Numerators in slot order x, y, z, w with the diagonal slot skipped.
    unique case (br)
      rmq_pkg::BR_TRACE: begin
        rad_s = t;
        n0 = n_d21m12; n1 = n_d02m20; n2 = n_d10m01;
      end
      rmq_pkg::BR_COL0: begin
        rad_s = ONE + e00 - e11 - e22;
        n0 = n_s10p01; n1 = n_s02p20; n2 = n_d21m12;
      end
      rmq_pkg::BR_COL1: begin
        rad_s = ONE + e11 - e00 - e22;
        n0 = n_s10p01; n1 = n_s21p12; n2 = n_d02m20;
      end
      default: begin
        rad_s = ONE + e22 - e00 - e11;
        n0 = n_s02p20; n1 = n_s21p12; n2 = n_d10m01;
      end
    endcase

    fr.branch = br;
    // Clamp a negative radicand to zero.
    fr.rad    = rad_s[EW-1] ? '0 : rad_s[rmq_pkg::RAD_W-1:0];
    fr.neg    = {n2[MW-1], n1[MW-1], n0[MW-1]};
    fr.mag[0] = mag_of(n0);
    fr.mag[1] = mag_of(n1);
    fr.mag[2] = mag_of(n2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld1;
    end
    out_data <= fr;
  end

endmodule

@@ hw/rtl/rmq_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, of rad * 2^30.
// Depends on rmq_pkg.
module rmq_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  rmq_pkg::front_t  in_data,
  output logic             out_vld,
  output rmq_pkg::root_t   out_data
);

  localparam int N  = rmq_pkg::ROOT_W;
  localparam int RW = N + 2;

  logic            vld  [0:N];
  logic [RW-1:0]   rem  [0:N];
  logic [N-1:0]    root [0:N];
  rmq_pkg::front_t side [0:N];

  assign vld[0]  = in_vld;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_data;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int P = N - 1 - k;
    logic [2*N-1:0] rv;
    logic [RW+1:0]  sh, trial;
    logic           take;

    always_comb begin
      rv    = {{(2*N-rmq_pkg::RAD_W-rmq_pkg::FRAC){1'b0}}, side[k].rad,
               {rmq_pkg::FRAC{1'b0}}};
      sh    = {rem[k], rv[2*P+1 -: 2]};
      trial = {2'b00, root[k], 2'b01};
      take  = (sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1]  <= take ? RW'(sh - trial) : RW'(sh);
      root[k+1] <= {root[k][N-2:0], take};
      side[k+1] <= side[k];
    end
  end

  always_comb begin
    out_vld         = vld[N];
    out_data.branch = side[N].branch;
    out_data.root   = root[N];
    out_data.neg    = side[N].neg;
    out_data.mag    = side[N].mag;
  end

endmodule

@@ hw/rtl/rmq_div.sv @@
// Three-lane pipelined restoring divider: (mag * 2^29) / root, one quotient bit per stage.
// Depends on rmq_pkg.
module rmq_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  rmq_pkg::root_t  in_data,
  output logic            out_vld,
  output rmq_pkg::quo_t   out_data
);

  localparam int N  = rmq_pkg::QUO_W;
  localparam int QW = rmq_pkg::ROOT_W;

  logic            vld  [0:N];
  logic [QW-1:0]   rem  [0:N][0:2];
  logic [N-1:0]    quo  [0:N][0:2];
  rmq_pkg::root_t  side [0:N];

  assign vld[0]  = in_vld;
  assign side[0] = in_data;
  for (genvar j = 0; j < 3; j++) begin : g_init
    assign rem[0][j] = '0;
    assign quo[0][j] = '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic [2:0] dbit;

    if (B >= rmq_pkg::DSH) begin : g_data
      for (genvar j = 0; j < 3; j++) begin : g_bit
        assign dbit[j] = side[k].mag[j][B-rmq_pkg::DSH];
      end
    end else begin : g_zero
      assign dbit = '0;
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [QW:0] sh;
      logic        take;
      always_comb begin
        sh   = {rem[k][j], dbit[j]};
        take = (sh >= {1'b0, side[k].root});
      end
      always_ff @(posedge clk) begin
        rem[k+1][j] <= take ? QW'(sh - {1'b0, side[k].root}) : QW'(sh);
        quo[k+1][j] <= {quo[k][j][N-2:0], take};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      side[k+1] <= side[k];
    end
  end

  always_comb begin
    out_vld         = vld[N];
    out_data.branch = side[N].branch;
    out_data.root   = side[N].root;
    out_data.neg    = side[N].neg;
    out_data.quo[0] = quo[N][0];
    out_data.quo[1] = quo[N][1];
    out_data.quo[2] = quo[N][2];
  end

endmodule

@@ hw/rtl/rmq_back.sv @@
// Back end: sign, saturation, placement of components by branch, degenerate flag, result register.
// Depends on rmq_pkg.
module rmq_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_vld,
  input  rmq_pkg::quo_t  in_data,
  output logic           done,
  output rmq_pkg::out_t  result
);

  localparam int DW = rmq_pkg::DATA_WIDTH;
  localparam int SW = rmq_pkg::SAT_W;
  localparam logic [SW-1:0] LIM = SW'(1) << (DW - 1);
  localparam logic [SW-1:0] HI  = LIM - SW'(1);

  logic [DW-1:0]  half;
  logic [DW-1:0]  v [0:2];
  rmq_pkg::out_t  res;

  // Apply the sign of the numerator and saturate to the signed output range.
  function automatic logic [DW-1:0] sat_of(input logic neg, input logic [SW-1:0] m);
    logic [SW-1:0] nm;
    nm = SW'(0) - m;
    if (!neg) begin
      sat_of = (m > HI) ? HI[DW-1:0] : m[DW-1:0];
    end else begin
      sat_of = (m > LIM) ? LIM[DW-1:0] : nm[DW-1:0];
    end
  endfunction

  always_comb begin
    half = sat_of(1'b0, SW'(in_data.root >> 1));
    for (int j = 0; j < 3; j++) begin
      v[j] = sat_of(in_data.neg[j], SW'(in_data.quo[j]));
    end

    res.branch_taken = in_data.branch;
    res.degenerate   = 1'b0;
    case (in_data.branch)
      rmq_pkg::BR_TRACE: begin
        res.quat_x = v[0]; res.quat_y = v[1]; res.quat_z = v[2]; res.quat_w = half;
      end
      rmq_pkg::BR_COL0: begin
        res.quat_x = half; res.quat_y = v[0]; res.quat_z = v[1]; res.quat_w = v[2];
      end
      rmq_pkg::BR_COL1: begin
        res.quat_x = v[0]; res.quat_y = half; res.quat_z = v[1]; res.quat_w = v[2];
      end
      default: begin
        res.quat_x = v[0]; res.quat_y = v[1]; res.quat_z = half; res.quat_w = v[2];
      end
    endcase

    // Zero root: force the quaternion to zero and flag it.
    if (in_data.root == '0) begin
      res.quat_x     = '0;
      res.quat_y     = '0;
      res.quat_z     = '0;
      res.quat_w     = '0;
      res.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
    result <= res;
  end

endmodule
